[hw/rtl/itoa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared constants, types and helpers of the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int VALUE_W   = 32;
  localparam int BCD_DIGITS = 10;
  localparam int DIGIT_W   = 4;
  localparam int EM_W      = BCD_DIGITS * DIGIT_W;  // 40-bit digit window
  localparam int CHAR_W    = 7;
  localparam int CNT_W     = 6;
  localparam int BIT_CNT_W = 5;

  // radix register codes
  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_BIN = 2'd1;
  localparam logic [1:0] RADIX_OCT = 2'd2;
  localparam logic [1:0] RADIX_HEX = 2'd3;

  // number of digits held in the window for each radix
  localparam logic [CNT_W-1:0] NDIG_DEC = 6'd10;
  localparam logic [CNT_W-1:0] NDIG_BIN = 6'd32;
  localparam logic [CNT_W-1:0] NDIG_OCT = 6'd11;
  localparam logic [CNT_W-1:0] NDIG_HEX = 6'd8;

  // ascii codes
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_UPA   = 7'h41;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_NONE  = 7'h00;

  // load request into the digit emitter
  typedef struct packed {
    logic            start;
    logic [1:0]      mode;
    logic            sign;
    logic            empty;
    logic [EM_W-1:0] digits;
  } emit_load_t;

  // result of the binary to bcd converter
  typedef struct packed {
    logic            done;
    logic [EM_W-1:0] digits;
  } bcd_res_t;

  // one digit to its upper-case ascii character
  function automatic logic [CHAR_W-1:0] char_of_digit(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < 4'd10) begin
      res = CH_ZERO + {3'b000, d};
    end else begin
      res = CH_UPA + {3'b000, d} - 7'd10;
    end
    return res;
  endfunction

endpackage

[hw/rtl/itoa_bcd.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_bcd
// Bit-serial binary to bcd converter (shift and add three), one bit a cycle.
// ----------------------------------------------------------------------------
module itoa_bcd (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [itoa_pkg::VALUE_W-1:0]       magnitude,
  output itoa_pkg::bcd_res_t                 res
);

  logic [itoa_pkg::VALUE_W-1:0]   mag_r, mag_nxt;
  logic [itoa_pkg::EM_W-1:0]      bcd_r, bcd_nxt;
  logic [itoa_pkg::BIT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt;
  logic [itoa_pkg::EM_W-1:0]      bcd_adj;

  // add three to every digit of five or more
  always_comb begin
    for (int i = 0; i < itoa_pkg::BCD_DIGITS; i++) begin
      if (bcd_r[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4];
      end
    end
  end

  // shift one magnitude bit into the bcd register per cycle
  always_comb begin
    mag_nxt  = mag_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      mag_nxt  = magnitude;
      bcd_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      mag_nxt = {mag_r[itoa_pkg::VALUE_W-2:0], 1'b0};
      bcd_nxt = {bcd_adj[itoa_pkg::EM_W-2:0], mag_r[itoa_pkg::VALUE_W-1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == {itoa_pkg::BIT_CNT_W{1'b1}}) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // final shift hands the digits straight on
  assign res.done   = busy_r && (cnt_r == {itoa_pkg::BIT_CNT_W{1'b1}});
  assign res.digits = {bcd_adj[itoa_pkg::EM_W-2:0], mag_r[itoa_pkg::VALUE_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
  end

endmodule

[hw/rtl/itoa_emit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_emit
// Digit emitter: skips leading zeros, then shifts out one character per cycle
// into the output register while out_stall allows it, sign first.
// ----------------------------------------------------------------------------
module itoa_emit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  itoa_pkg::emit_load_t          ld,
  output logic                          busy,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [itoa_pkg::CHAR_W-1:0]   out_ascii_char,
  output logic                          out_last,
  output logic                          out_empty_res
);

  localparam logic [1:0] E_IDLE = 2'd0;
  localparam logic [1:0] E_SKIP = 2'd1;
  localparam logic [1:0] E_OUT  = 2'd2;

  logic [1:0]                   state_r, state_nxt;
  logic [itoa_pkg::EM_W-1:0]    em_r, em_nxt;
  logic [itoa_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [1:0]                   mode_r, mode_nxt;
  logic                         sign_r, sign_nxt;
  logic                         empty_r, empty_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [itoa_pkg::CHAR_W-1:0]  char_r, char_nxt;
  logic                         last_r, last_nxt;
  logic                         emp_r, emp_nxt;
  logic [itoa_pkg::DIGIT_W-1:0] top_digit;
  logic [itoa_pkg::EM_W-1:0]    em_shift;
  logic [itoa_pkg::CNT_W-1:0]   ndig;
  logic                         out_free;
  logic                         out_load;

  // leading digit of the window and the window moved on by one digit
  always_comb begin
    case (mode_r)
      itoa_pkg::RADIX_BIN: begin
        top_digit = {3'b000, em_r[itoa_pkg::EM_W-1]};
        em_shift  = {em_r[itoa_pkg::EM_W-2:0], 1'b0};
      end
      itoa_pkg::RADIX_OCT: begin
        top_digit = {1'b0, em_r[itoa_pkg::EM_W-1 -: 3]};
        em_shift  = {em_r[itoa_pkg::EM_W-4:0], 3'b000};
      end
      default: begin
        top_digit = em_r[itoa_pkg::EM_W-1 -: 4];
        em_shift  = {em_r[itoa_pkg::EM_W-5:0], 4'b0000};
      end
    endcase
  end

  // digit count of a freshly loaded window
  always_comb begin
    case (ld.mode)
      itoa_pkg::RADIX_DEC: ndig = itoa_pkg::NDIG_DEC;
      itoa_pkg::RADIX_BIN: ndig = itoa_pkg::NDIG_BIN;
      itoa_pkg::RADIX_OCT: ndig = itoa_pkg::NDIG_OCT;
      default:             ndig = itoa_pkg::NDIG_HEX;
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;

  // skip and emit sequencer
  always_comb begin
    state_nxt = state_r;
    em_nxt    = em_r;
    cnt_nxt   = cnt_r;
    mode_nxt  = mode_r;
    sign_nxt  = sign_r;
    empty_nxt = empty_r;
    out_load  = 1'b0;
    char_nxt  = char_r;
    last_nxt  = last_r;
    emp_nxt   = emp_r;
    case (state_r)
      E_IDLE: begin
        if (ld.start) begin
          em_nxt    = ld.digits;
          cnt_nxt   = ndig;
          mode_nxt  = ld.mode;
          sign_nxt  = ld.sign;
          empty_nxt = ld.empty;
          state_nxt = ld.empty ? E_OUT : E_SKIP;
        end
      end
      E_SKIP: begin
        if ((cnt_r > 6'd1) && (top_digit == 4'd0)) begin
          em_nxt  = em_shift;
          cnt_nxt = cnt_r - 1'b1;
        end else begin
          state_nxt = E_OUT;
        end
      end
      E_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (empty_r) begin
            char_nxt  = itoa_pkg::CH_NONE;
            last_nxt  = 1'b1;
            emp_nxt   = 1'b1;
            state_nxt = E_IDLE;
          end else if (sign_r) begin
            char_nxt = itoa_pkg::CH_MINUS;
            last_nxt = 1'b0;
            emp_nxt  = 1'b0;
            sign_nxt = 1'b0;
          end else begin
            char_nxt = itoa_pkg::char_of_digit(top_digit);
            last_nxt = (cnt_r == 6'd1);
            emp_nxt  = 1'b0;
            em_nxt   = em_shift;
            cnt_nxt  = cnt_r - 1'b1;
            if (cnt_r == 6'd1) begin
              state_nxt = E_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = E_IDLE;
      end
    endcase
  end

  // output register holds a character until taken
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= E_IDLE;
      out_valid_r <= 1'b0;
      sign_r      <= 1'b0;
      empty_r     <= 1'b0;
      cnt_r       <= '0;
      mode_r      <= itoa_pkg::RADIX_DEC;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sign_r      <= sign_nxt;
      empty_r     <= empty_nxt;
      cnt_r       <= cnt_nxt;
      mode_r      <= mode_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    em_r   <= em_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
    emp_r  <= emp_nxt;
  end

  assign busy           = (state_r != E_IDLE);
  assign out_valid      = out_valid_r;
  assign out_ascii_char = char_r;
  assign out_last       = last_r;
  assign out_empty_res  = emp_r;

endmodule

[hw/rtl/integer_to_ascii_radix_formatter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_formatter
// Formats a signed 32-bit integer as ASCII text in decimal, binary, octal or
// hexadecimal, one character per result item, most significant digit first.
// ----------------------------------------------------------------------------
//  channel  ports                                     direction
//  in       in_valid, in_stall, in_value              item in
//  out      out_valid, out_stall, out_ascii_char,     item out
//           out_last, out_empty_res
//  cfg      cfg_wr_en, cfg_wr_data (radix_mode)       register write
//
//  flow: decimal items pass through bit-serial bcd conversion into 10 digit
//  slots, other radices load 32, 11 or 8 slots at once; the emitter then
//  skips leading zero slots, leaves the skip state and emits the characters,
//  sign first; a negative value outside decimal gives one empty item.
//  in_stall is high until the last character sits in the output register; a
//  held out_stall holds the emitter at its next character. Reset sets decimal.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_formatter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [itoa_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [itoa_pkg::CHAR_W-1:0]         out_ascii_char,
  output logic                                out_last,
  output logic                                out_empty_res,
  input  logic                                cfg_wr_en,
  input  logic [1:0]                          cfg_wr_data
);

  logic                          dec_sel;
  logic [1:0]                    radix_mode_r;
  logic                          conv_busy_r, conv_busy_nxt;
  logic                          sign_r, sign_nxt;
  logic                          accept;
  logic                          neg;
  logic                          emit_busy;
  logic                          bcd_start;
  logic [itoa_pkg::VALUE_W-1:0]  magnitude;
  itoa_pkg::bcd_res_t            bcd_res;
  itoa_pkg::emit_load_t          ld;

  assign dec_sel = (radix_mode_r == itoa_pkg::RADIX_DEC);

  // radix register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_mode_r <= itoa_pkg::RADIX_DEC;
    end else if (cfg_wr_en) begin
      radix_mode_r <= cfg_wr_data;
    end
  end

  assign in_stall  = conv_busy_r | emit_busy;
  assign accept    = in_valid && !in_stall;
  assign neg       = in_value[itoa_pkg::VALUE_W-1];
  assign magnitude = neg ? (~in_value + 1'b1) : in_value;
  assign bcd_start = accept && dec_sel;

  // decimal items go through the converter, the rest load the emitter at once
  always_comb begin
    conv_busy_nxt = conv_busy_r;
    sign_nxt      = sign_r;
    ld.start      = 1'b0;
    ld.mode       = radix_mode_r;
    ld.sign       = 1'b0;
    ld.empty      = neg;
    if (radix_mode_r == itoa_pkg::RADIX_OCT) begin
      ld.digits = {1'b0, in_value, 7'b0};
    end else begin
      ld.digits = {in_value, 8'b0};
    end
    if (bcd_start) begin
      conv_busy_nxt = 1'b1;
      sign_nxt      = neg;
    end else if (accept) begin
      ld.start = 1'b1;
    end else if (bcd_res.done) begin
      conv_busy_nxt = 1'b0;
      ld.start      = 1'b1;
      ld.mode       = itoa_pkg::RADIX_DEC;
      ld.sign       = sign_r;
      ld.empty      = 1'b0;
      ld.digits     = bcd_res.digits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_busy_r <= 1'b0;
      sign_r      <= 1'b0;
    end else begin
      conv_busy_r <= conv_busy_nxt;
      sign_r      <= sign_nxt;
    end
  end

  // bit-serial binary to bcd
  itoa_bcd u_bcd (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (bcd_start),
    .magnitude (magnitude),
    .res       (bcd_res)
  );

  // digit emitter and output register
  itoa_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .ld             (ld),
    .busy           (emit_busy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ascii_char (out_ascii_char),
    .out_last       (out_last),
    .out_empty_res  (out_empty_res)
  );

endmodule

[dv/itoa_text_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_text_checker
// Watches the item, result and radix ports of the integer to ASCII formatter,
// builds the expected text of every accepted value and checks each result
// item against it in order.
// ----------------------------------------------------------------------------
module itoa_text_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic signed [itoa_pkg::VALUE_W-1:0] in_value,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [itoa_pkg::CHAR_W-1:0]         out_ascii_char,
  input  logic                                out_last,
  input  logic                                out_empty_res,
  input  logic                                cfg_wr_en,
  input  logic [1:0]                          cfg_wr_data,
  output int                                  char_errors,
  output int                                  pending_chars
);

  localparam int MAX_TEXT = 32;
  localparam int SHOWN_ERRORS = 10;

  typedef struct packed {
    logic [itoa_pkg::CHAR_W-1:0] ch;
    logic                        last;
    logic                        empty;
  } text_char_t;

  text_char_t expected_text[$];
  logic [1:0] radix_copy;
  int         error_tally;

  // one digit to its upper-case character
  function automatic logic [itoa_pkg::CHAR_W-1:0] digit_glyph(
    input logic [itoa_pkg::DIGIT_W-1:0] d);
    logic [itoa_pkg::CHAR_W-1:0] glyph;
    if (d < 4'd10) begin
      glyph = itoa_pkg::CH_ZERO + {3'b000, d};
    end else begin
      glyph = itoa_pkg::CH_UPA + {3'b000, d} - 7'd10;
    end
    return glyph;
  endfunction

  // expected characters of one value, most significant digit first
  function automatic void queue_text(input logic [itoa_pkg::VALUE_W-1:0] value,
                                     input logic [1:0] radix);
    logic [itoa_pkg::VALUE_W-1:0] mag;
    logic [itoa_pkg::DIGIT_W-1:0] digits [MAX_TEXT];
    logic                         minus;
    int                           n_dig;
    int                           total;
    int                           pos;
    text_char_t                   c;
    minus = value[itoa_pkg::VALUE_W-1];
    // negative outside decimal: empty text, flagged on one item
    if (minus && radix != itoa_pkg::RADIX_DEC) begin
      c.ch = itoa_pkg::CH_NONE;
      c.last = 1'b1;
      c.empty = 1'b1;
      expected_text.push_back(c);
      return;
    end
    // magnitude is exact for the most negative value as well
    mag = minus ? (~value + 32'd1) : value;
    n_dig = 0;
    do begin
      case (radix)
        itoa_pkg::RADIX_DEC: begin
          digits[n_dig] = 4'(mag % 32'd10);
          mag = mag / 32'd10;
        end
        itoa_pkg::RADIX_BIN: begin
          digits[n_dig] = {3'b000, mag[0]};
          mag = mag >> 1;
        end
        itoa_pkg::RADIX_OCT: begin
          digits[n_dig] = {1'b0, mag[2:0]};
          mag = mag >> 3;
        end
        default: begin
          digits[n_dig] = mag[3:0];
          mag = mag >> 4;
        end
      endcase
      n_dig++;
    end while (mag != 0 && n_dig < MAX_TEXT);
    total = n_dig + int'(minus);
    if (total > MAX_TEXT) total = MAX_TEXT;
    pos = 0;
    if (minus) begin
      c.ch = itoa_pkg::CH_MINUS;
      c.last = (total == 1);
      c.empty = 1'b0;
      expected_text.push_back(c);
      pos++;
    end
    for (int i = n_dig - 1; i >= 0 && pos < total; i--) begin
      c.ch = digit_glyph(digits[i]);
      c.last = (pos == total - 1);
      c.empty = 1'b0;
      expected_text.push_back(c);
      pos++;
    end
  endfunction

  // compare results, predict new items, follow radix writes
  always @(posedge clk) begin
    text_char_t want;
    if (!rst_n) begin
      radix_copy = itoa_pkg::RADIX_DEC;
      expected_text.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_text.size() == 0) begin
          error_tally++;
          if (error_tally <= SHOWN_ERRORS)
            $display("%0t: unexpected result char %h last %b empty %b",
                     $realtime, out_ascii_char, out_last, out_empty_res);
        end else begin
          want = expected_text.pop_front();
          if (out_ascii_char !== want.ch || out_last !== want.last ||
              out_empty_res !== want.empty) begin
            error_tally++;
            if (error_tally <= SHOWN_ERRORS)
              $display("%0t: char exp %h got %h, last exp %b got %b, empty exp %b got %b",
                       $realtime, want.ch, out_ascii_char, want.last, out_last,
                       want.empty, out_empty_res);
          end
        end
      end
      if (in_valid && !in_stall) queue_text(in_value, radix_copy);
      if (cfg_wr_en) radix_copy = cfg_wr_data;
    end
    char_errors <= error_tally;
    pending_chars <= expected_text.size();
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the integer to ASCII formatter with directed and random values in
// all four radices under varied sender and receiver idling, including one
// long receiver hold-off, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb;

  localparam int QUIET_LIMIT = 4000;
  localparam int LONG_HOLD = 400;
  localparam int ITEMS_PER_BLOCK = 34;

  logic                                clk;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic signed [itoa_pkg::VALUE_W-1:0] in_value = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [itoa_pkg::CHAR_W-1:0]         out_ascii_char;
  logic                                out_last;
  logic                                out_empty_res;
  logic                                cfg_wr_en = 1'b0;
  logic [1:0]                          cfg_wr_data = itoa_pkg::RADIX_DEC;

  int char_errors;
  int pending_chars;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;

  integer_to_ascii_radix_formatter i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ascii_char (out_ascii_char),
    .out_last       (out_last),
    .out_empty_res  (out_empty_res),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  itoa_text_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ascii_char (out_ascii_char),
    .out_last       (out_last),
    .out_empty_res  (out_empty_res),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .char_errors    (char_errors),
    .pending_chars  (pending_chars)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: random stalls, or a long hold-off on request
  always @(negedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // cycles with no item moving on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("FAIL integer_to_ascii_radix_formatter");
    $finish;
  end

  // offer one value, with random idle cycles ahead of it
  task automatic send_value(input logic signed [itoa_pkg::VALUE_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // let the text drain, then write the radix register
  task automatic change_radix(input logic [1:0] mode);
    in_valid <= 1'b0;
    while (pending_chars != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= mode;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // random value, biased towards short texts and boundaries
  function automatic logic [itoa_pkg::VALUE_W-1:0] pick_value();
    logic [itoa_pkg::VALUE_W-1:0] r;
    r = $urandom();
    case ($urandom_range(9))
      4, 5: r = $urandom_range(99);
      6: r = 32'd0 - $urandom_range(99, 1);
      7: r = (32'd1 << $urandom_range(31)) - 32'($urandom_range(1));
      8: begin
        case ($urandom_range(3))
          0: r = 32'h0000_0000;
          1: r = 32'h7FFF_FFFF;
          2: r = 32'h8000_0000;
          default: r = 32'hFFFF_FFFF;
        endcase
      end
      9: r = {1'b0, r[30:0]} >> $urandom_range(30);
      default: ;
    endcase
    return r;
  endfunction

  task automatic random_block(input logic [1:0] mode);
    change_radix(mode);
    repeat (ITEMS_PER_BLOCK) send_value(pick_value());
  endtask

  // stimulus and verdict
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 30;
    recv_stall_pct = 63;

    // decimal: zero, single digits, sign, extremes
    change_radix(itoa_pkg::RADIX_DEC);
    send_value(0);
    send_value(1);
    send_value(-1);
    send_value(9);
    send_value(10);
    send_value(-10);
    send_value(32'sh7FFF_FFFF);
    send_value(32'sh8000_0000);
    send_value(1000000000);

    // binary: zero, one, longest text, negative gives empty text
    change_radix(itoa_pkg::RADIX_BIN);
    send_value(0);
    send_value(1);
    send_value(32'sh7FFF_FFFF);
    send_value(-1);
    send_value(32'sh4000_0000);

    change_radix(itoa_pkg::RADIX_OCT);
    send_value(0);
    send_value(7);
    send_value(8);
    send_value(32'sh7FFF_FFFF);
    send_value(32'sh8000_0000);

    // hex: every digit glyph between the two patterns
    change_radix(itoa_pkg::RADIX_HEX);
    send_value(0);
    send_value(15);
    send_value(16);
    send_value(32'sh7FED_CBA9);
    send_value(32'sh1234_5680);
    send_value(32'sh8000_0000);

    // random values under three idling patterns
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 30;
          recv_stall_pct = 63;
        end
        1: begin
          send_idle_pct = 63;
          recv_stall_pct = 30;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      random_block(itoa_pkg::RADIX_DEC);
      if (phase == 2) begin
        // long receiver hold-off while values keep coming
        change_radix(itoa_pkg::RADIX_BIN);
        hold_requests++;
        repeat (ITEMS_PER_BLOCK) send_value(pick_value());
      end else begin
        random_block(itoa_pkg::RADIX_BIN);
      end
      random_block(itoa_pkg::RADIX_OCT);
      random_block(itoa_pkg::RADIX_HEX);
    end

    in_valid <= 1'b0;
    while (pending_chars != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (char_errors == 0) begin
      $display("PASS integer_to_ascii_radix_formatter");
    end else begin
      $display("FAIL integer_to_ascii_radix_formatter");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/itoa_pkg.sv
hw/rtl/itoa_bcd.sv
hw/rtl/itoa_emit.sv
hw/rtl/integer_to_ascii_radix_formatter.sv
dv/itoa_text_checker.sv
dv/tb.sv
